FILE: rtl/periodic_job_alarm_scheduler_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the periodic job alarm scheduler
// Clocked implication checks with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_JOB_ALARM_SCHEDULER_ASSERT_SVH
`define PERIODIC_JOB_ALARM_SCHEDULER_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PJAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define PJAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pjas_pkg.sv
// ---------------------------------------------------------------------------
// Periodic job alarm scheduler package
// Command codes and fixed field widths shared by the scheduler.
// ---------------------------------------------------------------------------
package pjas_pkg;

  localparam int TIME_W  = 32;
  localparam int MASK_W  = 8;
  localparam int COUNT_W = 4;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_ADD     = 3'd0;
  localparam cmd_t CMD_ALARM   = 3'd1;
  localparam cmd_t CMD_STOP    = 3'd2;
  localparam cmd_t CMD_COLLECT = 3'd3;
  localparam cmd_t CMD_CLEAR   = 3'd4;

  // One table entry: period in the upper half, remaining time in the lower.
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] remaining;
  } job_entry_t;

endpackage

FILE: rtl/pjas_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ---------------------------------------------------------------------------
module pjas_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/periodic_job_alarm_scheduler.sv
// ---------------------------------------------------------------------------
// Periodic job alarm scheduler
// Table of periodic jobs held in RAM, walked entry by entry to age the jobs
// and to find the earliest next alarm.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_command, in_now, in_period
//   out_     output     out_valid / out_ready  out_accepted, out_alarm_set,
//                                              out_alarm_time, out_alarm_cancel,
//                                              out_running, out_pending_mask,
//                                              out_job_count
//
// Add, collect, clear, an alarm with no elapsed time while running, a stop
// while stopped and the unused codes go straight to the finish state and
// raise out_valid once the output register is free.
// Alarm/start and a stop while running walk the job RAM, one read per cycle
// through a read, update and minimum pipeline.
// One command is in flight at a time; the next transfer is taken as soon as
// the result has moved to the output register, even while that waits.
// rst_n is synchronous: it empties the table and clears pending marks and the
// running flag. The RAM itself is never cleared, as entries are written by add
// before they are read.
//
module periodic_job_alarm_scheduler
  import pjas_pkg::*;
#(
  parameter int MAX_JOBS = 8
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  cmd_t              in_command,
  input  logic [TIME_W-1:0] in_now,
  input  logic [TIME_W-1:0] in_period,

  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic               out_alarm_set,
  output logic [TIME_W-1:0]  out_alarm_time,
  output logic               out_alarm_cancel,
  output logic               out_running,
  output logic [MASK_W-1:0]  out_pending_mask,
  output logic [COUNT_W-1:0] out_job_count
);

`include "periodic_job_alarm_scheduler_assert.svh"

  // Address width for the table, count width able to hold MAX_JOBS itself.
  localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_JOBS);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Control state.
  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  logic [MAX_JOBS-1:0] pend_r, pend_nxt;
  logic [CW-1:0]       iss_r, iss_nxt;
  logic                dv_r, dv_nxt;
  logic                nv_r, nv_nxt;
  logic                first_r, first_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Per-command working registers.
  cmd_t                cmd_r, cmd_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic                do_work_r, do_work_nxt;
  logic [AW-1:0]       wb_r, wb_nxt;
  logic [TIME_W-1:0]   nrem_r, nrem_nxt;
  logic [TIME_W-1:0]   min_r, min_nxt;

  // Result under construction.
  logic                acc_r, acc_nxt;
  logic                set_r, set_nxt;
  logic [TIME_W-1:0]   atime_r, atime_nxt;
  logic                cancel_r, cancel_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;

  // Output register.
  logic                out_load;
  logic                o_acc_r;
  logic                o_set_r;
  logic [TIME_W-1:0]   o_atime_r;
  logic                o_cancel_r;
  logic                o_run_r;
  logic [MASK_W-1:0]   o_mask_r;
  logic [COUNT_W-1:0]  o_count_r;

  // RAM ports.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  job_entry_t          ram_wdata;
  job_entry_t          ram_rdata;
  logic [2*TIME_W-1:0] ram_rdata_raw;

  // Helper values.
  logic [MAX_JOBS-1:0]        inuse;
  logic [MAX_JOBS+MASK_W-1:0] mask_ext;
  logic [CW+COUNT_W-1:0]      cnt_ext;
  logic [TIME_W-1:0]          elapsed_in;
  logic                       hit;

  pjas_ram #(
    .WIDTH (2 * TIME_W),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (iss_r[AW-1:0]),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = job_entry_t'(ram_rdata_raw);

  // Bit i is set for every job slot in use.
  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      inuse[i] = (CW'(i) < cnt_r);
    end
  end

  // Only jobs 0 to 7 show in the mask; a narrower table is zero-extended.
  assign mask_ext   = {{MASK_W{1'b0}}, pend_r & inuse};
  assign cnt_ext    = {{COUNT_W{1'b0}}, cnt_r};
  assign elapsed_in = in_now - start_r;
  assign in_ready   = (state_r == ST_IDLE);
  assign out_load   = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // An entry is used up when the elapsed time reaches its remaining time.
  assign hit = do_work_r && (elapsed_r >= ram_rdata.remaining);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    pend_nxt      = pend_r;
    iss_nxt       = iss_r;
    dv_nxt        = 1'b0;
    nv_nxt        = 1'b0;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    elapsed_nxt   = elapsed_r;
    do_work_nxt   = do_work_r;
    wb_nxt        = wb_r;
    nrem_nxt      = nrem_r;
    min_nxt       = min_r;
    acc_nxt       = acc_r;
    set_nxt       = set_r;
    atime_nxt     = atime_r;
    cancel_nxt    = cancel_r;
    mask_nxt      = mask_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = '{period: in_period, remaining: in_period};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_command;
          now_nxt     = in_now;
          elapsed_nxt = elapsed_in;
          iss_nxt     = '0;
          first_nxt   = 1'b1;
          acc_nxt     = 1'b0;
          set_nxt     = 1'b0;
          atime_nxt   = '0;
          cancel_nxt  = 1'b0;
          mask_nxt    = '0;
          state_nxt   = ST_FIN;
          unique case (in_command)
            CMD_ADD: begin
              if (!run_r && (cnt_r < MAX_CNT) && (in_period != '0)) begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                acc_nxt = 1'b1;
                for (int i = 0; i < MAX_JOBS; i++) begin
                  if (CW'(i) == cnt_r) begin
                    pend_nxt[i] = 1'b0;
                  end
                end
              end
            end
            CMD_ALARM: begin
              // Running with no time gone by: nothing to do.
              if (!(run_r && (elapsed_in == '0))) begin
                do_work_nxt = run_r;
                state_nxt   = ST_WALK;
              end
            end
            CMD_STOP: begin
              if (run_r) begin
                cancel_nxt  = 1'b1;
                do_work_nxt = (elapsed_in != '0);
                state_nxt   = ST_WALK;
              end
            end
            CMD_COLLECT: begin
              mask_nxt = mask_ext[MASK_W-1:0];
              pend_nxt = pend_r & ~inuse;
            end
            CMD_CLEAR: begin
              pend_nxt  = '0;
              cnt_nxt   = '0;
              run_nxt   = 1'b0;
              start_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        // Stage 0: issue one read per cycle over the slots in use.
        if (iss_r != cnt_r) begin
          iss_nxt = iss_r + 1'b1;
          dv_nxt  = 1'b1;
          wb_nxt  = iss_r[AW-1:0];
        end
        // Stage 1: age the entry just read and write it back.
        if (dv_r) begin
          nv_nxt = 1'b1;
          if (!do_work_r) begin
            nrem_nxt = ram_rdata.remaining;
          end else if (hit) begin
            nrem_nxt = ram_rdata.period;
          end else begin
            nrem_nxt = ram_rdata.remaining - elapsed_r;
          end
          if (do_work_r) begin
            ram_we    = 1'b1;
            ram_waddr = wb_r;
            ram_wdata = '{period: ram_rdata.period, remaining: nrem_nxt};
          end
          if (hit) begin
            for (int i = 0; i < MAX_JOBS; i++) begin
              if (AW'(i) == wb_r) begin
                pend_nxt[i] = 1'b1;
              end
            end
          end
        end
        // Stage 2: running minimum of the updated remaining times.
        if (nv_r) begin
          if (first_r || (nrem_r < min_r)) begin
            min_nxt = nrem_r;
          end
          first_nxt = 1'b0;
        end
        // Pipeline drained: arm the alarm or stop.
        if ((iss_r == cnt_r) && !dv_r && !nv_r) begin
          state_nxt = ST_FIN;
          if (cmd_r == CMD_ALARM) begin
            if (!first_r && (min_r != '0)) begin
              start_nxt = now_r;
              atime_nxt = now_r + min_r;
              set_nxt   = 1'b1;
              run_nxt   = 1'b1;
            end
          end else begin
            run_nxt = 1'b0;
          end
        end
      end

      ST_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      run_r       <= 1'b0;
      start_r     <= '0;
      pend_r      <= '0;
      iss_r       <= '0;
      dv_r        <= 1'b0;
      nv_r        <= 1'b0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      run_r       <= run_nxt;
      start_r     <= start_nxt;
      pend_r      <= pend_nxt;
      iss_r       <= iss_nxt;
      dv_r        <= dv_nxt;
      nv_r        <= nv_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers carry no reset.
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    now_r     <= now_nxt;
    elapsed_r <= elapsed_nxt;
    do_work_r <= do_work_nxt;
    wb_r      <= wb_nxt;
    nrem_r    <= nrem_nxt;
    min_r     <= min_nxt;
    acc_r     <= acc_nxt;
    set_r     <= set_nxt;
    atime_r   <= atime_nxt;
    cancel_r  <= cancel_nxt;
    mask_r    <= mask_nxt;
    if (out_load) begin
      o_acc_r    <= acc_r;
      o_set_r    <= set_r;
      o_atime_r  <= atime_r;
      o_cancel_r <= cancel_r;
      o_run_r    <= run_r;
      o_mask_r   <= mask_r;
      o_count_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = o_acc_r;
  assign out_alarm_set    = o_set_r;
  assign out_alarm_time   = o_atime_r;
  assign out_alarm_cancel = o_cancel_r;
  assign out_running      = o_run_r;
  assign out_pending_mask = o_mask_r;
  assign out_job_count    = o_count_r;

  // The read/update pipeline is empty whenever a new command can be taken.
  `PJAS_ASSERT_NOW(a_pipe_empty_on_idle, clk, rst_n, in_ready, !dv_r && !nv_r, "walk pipeline busy while idle")
  // Write-backs during a walk only happen from the update stage.
  `PJAS_ASSERT_NOW(a_walk_write_stage, clk, rst_n, ram_we && (state_r == ST_WALK), dv_r && do_work_r, "table write outside update stage")
  // The table never grows past its depth.
  `PJAS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_r <= MAX_CNT, "job count beyond table depth")
  // Slots not in use never carry a pending mark.
  `PJAS_ASSERT_NOW(a_pend_in_use, clk, rst_n, 1'b1, (pend_r & ~inuse) == '0, "pending mark on an empty slot")
  // A successful add is only possible while stopped.
  `PJAS_ASSERT_NEXT(a_add_stopped, clk, rst_n, out_load && acc_r, !o_run_r, "job added while running")

endmodule

FILE: dv/pjas_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Periodic job alarm scheduler checker
// Watches both channels of the scheduler, keeps its own copy of the job table
// and predicts the status of every command, then compares each returned
// status field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module pjas_checker
  import pjas_pkg::*;
#(
  parameter int MAX_JOBS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cmd_t               in_command,
  input  logic [TIME_W-1:0]  in_now,
  input  logic [TIME_W-1:0]  in_period,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_accepted,
  input  logic               out_alarm_set,
  input  logic [TIME_W-1:0]  out_alarm_time,
  input  logic               out_alarm_cancel,
  input  logic               out_running,
  input  logic [MASK_W-1:0]  out_pending_mask,
  input  logic [COUNT_W-1:0] out_job_count,
  output int                 fail_count,
  output int                 outstanding,
  output int                 checked
);

  typedef struct packed {
    logic               accepted;
    logic               alarm_set;
    logic [TIME_W-1:0]  alarm_time;
    logic               alarm_cancel;
    logic               running;
    logic [MASK_W-1:0]  pending_mask;
    logic [COUNT_W-1:0] job_count;
  } sched_status_t;

  // Shadow of the scheduler state.
  logic [TIME_W-1:0] job_period_q    [MAX_JOBS];
  logic [TIME_W-1:0] job_remaining_q [MAX_JOBS];
  logic              job_pending_q   [MAX_JOBS];
  int unsigned       jobs_held;
  logic              sched_running;
  logic [TIME_W-1:0] armed_epoch;

  sched_status_t predicted_status[$];
  int            mismatches;
  int            compared;

  // Take elapsed seconds off every job; a job that runs out reloads and pends.
  function automatic void age_jobs(logic [TIME_W-1:0] elapsed);
    for (int i = 0; i < jobs_held && i < MAX_JOBS; i++) begin
      if (elapsed >= job_remaining_q[i]) begin
        job_remaining_q[i] = job_period_q[i];
        job_pending_q[i]   = 1'b1;
      end else begin
        job_remaining_q[i] = job_remaining_q[i] - elapsed;
      end
    end
  endfunction

  function automatic sched_status_t apply_command(cmd_t cmd, logic [TIME_W-1:0] now,
                                                  logic [TIME_W-1:0] per);
    sched_status_t     st;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] soonest;
    logic              rearm;
    st    = '0;
    rearm = 1'b1;
    case (cmd)
      CMD_ADD: begin
        if (!sched_running && jobs_held < MAX_JOBS && per != '0) begin
          job_period_q[jobs_held]    = per;
          job_remaining_q[jobs_held] = per;
          job_pending_q[jobs_held]   = 1'b0;
          jobs_held++;
          st.accepted = 1'b1;
        end
      end
      CMD_ALARM: begin
        if (sched_running) begin
          elapsed = now - armed_epoch;
          if (elapsed != '0) begin
            age_jobs(elapsed);
          end else begin
            rearm = 1'b0;
          end
        end
        if (rearm && jobs_held > 0) begin
          soonest = job_remaining_q[0];
          for (int i = 1; i < jobs_held && i < MAX_JOBS; i++) begin
            if (job_remaining_q[i] < soonest) soonest = job_remaining_q[i];
          end
          if (soonest != '0) begin
            armed_epoch   = now;
            st.alarm_time = now + soonest;
            st.alarm_set  = 1'b1;
            sched_running = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        if (sched_running) begin
          elapsed = now - armed_epoch;
          st.alarm_cancel = 1'b1;
          if (elapsed != '0) age_jobs(elapsed);
          sched_running = 1'b0;
        end
      end
      CMD_COLLECT: begin
        for (int i = 0; i < jobs_held && i < MAX_JOBS; i++) begin
          if (job_pending_q[i]) begin
            if (i < MASK_W) st.pending_mask[i] = 1'b1;
            job_pending_q[i] = 1'b0;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < MAX_JOBS; i++) job_pending_q[i] = 1'b0;
        jobs_held     = 0;
        sched_running = 1'b0;
        armed_epoch   = '0;
      end
      default: ;
    endcase
    st.running   = sched_running;
    st.job_count = jobs_held[COUNT_W-1:0];
    return st;
  endfunction

  task automatic report_field(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    sched_status_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_JOBS; i++) job_pending_q[i] = 1'b0;
      jobs_held     = 0;
      sched_running = 1'b0;
      armed_epoch   = '0;
      predicted_status.delete();
      mismatches    = 0;
      compared      = 0;
    end else begin
      // The returned status always belongs to an earlier command, so compare first.
      if (out_valid && out_ready) begin
        if (predicted_status.size() == 0) begin
          $display("%0t: status transfer with none expected, actual accepted=%0b set=%0b time=%0h",
                   $time, out_accepted, out_alarm_set, out_alarm_time);
          mismatches++;
        end else begin
          want = predicted_status.pop_front();
          report_field("accepted", TIME_W'(want.accepted), TIME_W'(out_accepted));
          report_field("alarm_set", TIME_W'(want.alarm_set), TIME_W'(out_alarm_set));
          report_field("alarm_time", want.alarm_time, out_alarm_time);
          report_field("alarm_cancel", TIME_W'(want.alarm_cancel), TIME_W'(out_alarm_cancel));
          report_field("running", TIME_W'(want.running), TIME_W'(out_running));
          report_field("pending_mask", TIME_W'(want.pending_mask), TIME_W'(out_pending_mask));
          report_field("job_count", TIME_W'(want.job_count), TIME_W'(out_job_count));
          compared++;
        end
      end
      if (in_valid && in_ready) begin
        predicted_status.push_back(apply_command(in_command, in_now, in_period));
      end
    end
    fail_count  <= mismatches;
    outstanding <= predicted_status.size();
    checked     <= compared;
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Periodic job alarm scheduler testbench
// Drives directed commands and random job episodes (add jobs, start,
// age the jobs through a run of alarms, collect, stop) with random idling on
// both channels; a separate checker predicts and compares every status.
// ---------------------------------------------------------------------------
module testbench;
  import pjas_pkg::*;

  localparam int JOBS        = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEM_TARGET = 650;
  localparam int HOLD_CYCLES = 400;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cmd_t               in_command;
  logic [TIME_W-1:0]  in_now;
  logic [TIME_W-1:0]  in_period;
  logic               out_valid;
  logic               out_ready;
  logic               out_accepted;
  logic               out_alarm_set;
  logic [TIME_W-1:0]  out_alarm_time;
  logic               out_alarm_cancel;
  logic               out_running;
  logic [MASK_W-1:0]  out_pending_mask;
  logic [COUNT_W-1:0] out_job_count;

  int fail_count;
  int outstanding;
  int checked;
  int commands_sent;
  int statuses_taken;
  int cycle_count;

  always #5 clk = ~clk;

  periodic_job_alarm_scheduler #(.MAX_JOBS(JOBS)) uut (.*);

  pjas_checker #(.MAX_JOBS(JOBS)) checker_i (.*);

  // A generous ceiling: the slowest correct run is far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("periodic_job_alarm_scheduler test failed");
      $finish;
    end
  end

  // One transfer on the command channel. Every third group of forty commands
  // goes back to back so that the block also sees stretches without gaps.
  // The valid line is only lowered when a gap follows, so it is never dropped
  // and raised again in the same time step.
  task automatic send_command(cmd_t cmd, logic [TIME_W-1:0] now, logic [TIME_W-1:0] per);
    int gap;
    gap = ((commands_sent / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_now     <= now;
    in_period  <= per;
    do @(posedge clk); while (!in_ready);
    commands_sent++;
  endtask

  // Lower valid and wait until every predicted status has come back.
  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Periods are mostly short so that jobs expire within a few alarms; a few
  // are zero (rejected) and a few span the whole 32-bit range.
  function automatic logic [TIME_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 40);
    if (roll < 80) return '0;
    return $urandom;
  endfunction

  // Time advance between alarms: usually a few seconds, sometimes none at
  // all, sometimes a huge jump that wraps the epoch counter.
  function automatic logic [TIME_W-1:0] pick_step();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 30);
    if (roll < 88) return '0;
    return $urandom;
  endfunction

  // A well-formed episode: optionally empty the table, add jobs while stopped,
  // start, then a run of alarms with collects, stops, restarts and the odd
  // stray command in between.
  task automatic job_episode();
    int                n_add;
    int                n_steps;
    int                roll;
    logic [TIME_W-1:0] epoch;
    if ($urandom_range(0, 1)) send_command(CMD_CLEAR, $urandom, $urandom);
    n_add = $urandom_range(0, 10);
    for (int k = 0; k < n_add; k++) send_command(CMD_ADD, $urandom, pick_period());
    epoch = $urandom;
    send_command(CMD_ALARM, epoch, $urandom);
    n_steps = $urandom_range(4, 16);
    for (int k = 0; k < n_steps; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        epoch += pick_step();
        send_command(CMD_ALARM, epoch, $urandom);
      end else if (roll < 73) begin
        send_command(CMD_COLLECT, epoch, $urandom);
      end else if (roll < 83) begin
        // Stop, top the table up while stopped and start again.
        epoch += pick_step();
        send_command(CMD_STOP, epoch, $urandom);
        repeat ($urandom_range(0, 2)) send_command(CMD_ADD, epoch, pick_period());
        epoch += pick_step();
        send_command(CMD_ALARM, epoch, $urandom);
      end else if (roll < 90) begin
        send_command(CMD_ADD, epoch, pick_period());
      end else begin
        send_command(cmd_t'($urandom_range(0, 7)), $urandom, $urandom);
      end
    end
    send_command(CMD_COLLECT, epoch, $urandom);
  endtask

  // Status receiver: draws a stall before each status, with every third group
  // of fifty taken without stalls. Once, after the 120th status, it holds off
  // for a long stretch while the sender keeps offering commands, so the
  // output register fills and the command channel backs up.
  initial begin : status_receiver
    int  stall;
    bit  held_off;
    held_off  = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && statuses_taken == 120) begin
        held_off  = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = ((statuses_taken / 50) % 3 == 2) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      statuses_taken++;
    end
  end

  initial begin : command_sender
    bit drained_once;
    drained_once = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_ADD;
    in_now     <= '0;
    in_period  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Fill the table to the brim with extreme periods, check
    // that a zero period and a ninth job are refused, start just below the
    // top of the epoch so the alarm lands on the last second, repeat an alarm
    // with no time gone by, try to add while running, let the epoch wrap,
    // then collect, stop twice, send the unused codes and start on an empty
    // table.
    send_command(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_ADD, 32'h0, 32'h0);
    send_command(CMD_ADD, 32'h0, 32'h1);
    send_command(CMD_ADD, 32'h0, 32'hFFFF_FFFF);
    send_command(CMD_ADD, 32'h0, 32'h2);
    send_command(CMD_ADD, 32'h0, 32'h3);
    send_command(CMD_ADD, 32'h0, 32'h5);
    send_command(CMD_ADD, 32'h0, 32'h7);
    send_command(CMD_ADD, 32'h0, 32'h8000_0000);
    send_command(CMD_ADD, 32'h0, 32'd100);
    send_command(CMD_ADD, 32'h0, 32'h9);
    send_command(CMD_ALARM, 32'hFFFF_FFFE, 32'h0);
    send_command(CMD_ALARM, 32'hFFFF_FFFE, 32'h0);
    send_command(CMD_ADD, 32'hFFFF_FFFE, 32'h4);
    send_command(CMD_ALARM, 32'h0000_0003, 32'h0);
    send_command(CMD_COLLECT, 32'h0000_0003, 32'h0);
    send_command(CMD_STOP, 32'h0000_0010, 32'h0);
    send_command(CMD_STOP, 32'h0000_0020, 32'h0);
    send_command(cmd_t'(5), 32'hAAAA_AAAA, 32'h5555_5555);
    send_command(cmd_t'(6), 32'h5555_5555, 32'hAAAA_AAAA);
    send_command(cmd_t'(7), 32'hFFFF_FFFF, 32'h0);
    send_command(CMD_CLEAR, 32'h0, 32'h0);
    send_command(CMD_ALARM, 32'h1234_5678, 32'h0);
    send_command(CMD_COLLECT, 32'h0, 32'h0);

    // Random episodes. Once, past the middle of the run, the sender stops
    // and lets the block empty completely before carrying on.
    while (commands_sent < ITEM_TARGET) begin
      job_episode();
      if (!drained_once && commands_sent >= 450) begin
        drained_once = 1'b1;
        drain_block();
      end
    end

    // Wait for the last status, then well past the time the slowest
    // command takes, in case something unexpected comes out.
    drain_block();
    repeat (4 * (JOBS + 4)) @(posedge clk);

    $display("Covered %0d commands: directed edge cases, then random add/start/alarm episodes",
             commands_sent);
    $display("with one long receiver hold-off and one full drain; %0d statuses checked.", checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("periodic_job_alarm_scheduler test passed");
    end else begin
      $display("periodic_job_alarm_scheduler test failed");
    end
    $finish;
  end

endmodule
